// File: hw/rtl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared widths, operation and error codes, and the control structs that pass
// between the top level and the bit-serial units of the signed integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package ialu_pkg;

    // Data path width and the width of a bit counter over it.
    localparam int DW = 32;
    localparam int CW = $clog2(DW);

    // Last iteration index of a full-width serial pass.
    localparam logic [CW-1:0] LAST_BIT = CW'(DW - 1);

    // Largest shift amount that is accepted.
    localparam logic [DW-1:0] SHIFT_MAX = DW'(DW - 2);

    // Operation codes.
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_OR  = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_NOT = 4'd7;
    localparam logic [3:0] OP_SHL = 4'd8;
    localparam logic [3:0] OP_SHR = 4'd9;

    // Error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_OVF   = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_SHIFT = 2'd3;

    // Command to the multiply / divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_cmd;

    // Command to the shift unit.
    typedef struct packed {
        logic start;
        logic left;
    } t_sh_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/ialu_muldiv.sv
// ----------------------------------------------------------------------------
// ialu_muldiv
// Unsigned shift-add multiplier and restoring divider sharing one register
// pair; one bit of the multiplier or quotient is resolved per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_muldiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ialu_pkg::t_md_cmd         i_cmd,
    input  logic [ialu_pkg::DW-1:0]   i_op_x,   // multiplicand or divisor
    input  logic [ialu_pkg::DW-1:0]   i_op_y,   // multiplier or dividend
    output logic                      o_done,
    output logic [ialu_pkg::DW-1:0]   o_hi,     // product high half
    output logic [ialu_pkg::DW-1:0]   o_lo      // product low half or quotient
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_div;
    logic [ialu_pkg::CW-1:0] r_cnt;
    logic [ialu_pkg::DW-1:0] r_x;
    logic [ialu_pkg::DW-1:0] r_hi, n_hi;
    logic [ialu_pkg::DW-1:0] r_lo, n_lo;

    logic [ialu_pkg::DW:0]   w_sum;
    logic [ialu_pkg::DW+1:0] w_diff;
    logic                    w_borrow;

    // Multiply: add the multiplicand into the high half when the current
    // multiplier bit is set, then shift the whole pair right by one.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_x} : {(ialu_pkg::DW+1){1'b0}});

    // Divide: shift the next dividend bit into the remainder and try a subtract.
    assign w_diff   = {1'b0, r_hi, r_lo[ialu_pkg::DW-1]} - {2'b00, r_x};
    assign w_borrow = w_diff[ialu_pkg::DW+1];

    always_comb begin
        if (r_div) begin
            n_hi = w_borrow ? {r_hi[ialu_pkg::DW-2:0], r_lo[ialu_pkg::DW-1]}
                            : w_diff[ialu_pkg::DW-1:0];
            n_lo = {r_lo[ialu_pkg::DW-2:0], ~w_borrow};
        end else begin
            n_hi = w_sum[ialu_pkg::DW:1];
            n_lo = {w_sum[0], r_lo[ialu_pkg::DW-1:1]};
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == ialu_pkg::LAST_BIT)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_div <= i_cmd.is_div;
            r_x   <= i_op_x;
            r_hi  <= '0;
            r_lo  <= i_op_y;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

endmodule

`default_nettype wire

// File: hw/rtl/ialu_shift.sv
// ----------------------------------------------------------------------------
// ialu_shift
// Bit-serial shifter: moves the operand one place per cycle, left or
// arithmetic right, until the requested amount is used up.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_shift (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ialu_pkg::t_sh_cmd         i_cmd,
    input  logic [ialu_pkg::DW-1:0]   i_data,
    input  logic [ialu_pkg::CW-1:0]   i_amount,
    output logic                      o_done,
    output logic [ialu_pkg::DW-1:0]   o_data
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_left;
    logic [ialu_pkg::CW-1:0] r_cnt;
    logic [ialu_pkg::DW-1:0] r_data;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == '0)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_left <= i_cmd.left;
            r_data <= i_data;
            r_cnt  <= i_amount;
        end else if (r_busy && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_left) begin
                r_data <= {r_data[ialu_pkg::DW-2:0], 1'b0};
            end else begin
                r_data <= {r_data[ialu_pkg::DW-1], r_data[ialu_pkg::DW-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_data = r_data;

endmodule

`default_nettype wire

// File: hw/rtl/signed_int32_alu_mul_div_top.sv
// ----------------------------------------------------------------------------
// signed_int32_alu_mul_div_top
// 32-bit signed integer ALU with bit-serial multiply, divide and shifts.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  req       in         i_req_valid / o_req_ready    i_req_type, i_operand_a, i_operand_b
//  rsp       out        o_rsp_valid / i_rsp_ready    o_result, o_error_code
//
//  One request at a time. Add, subtract, logic ops and rejected requests
//  pass through S_SETUP and S_DONE to a valid response; multiply and divide
//  also pass S_MULDIV and S_FIX, with the one-bit-per-cycle shift-add /
//  restoring-divide loop; shifts pass S_SHIFT, with the one-place-per-cycle shifter.
//  A new request is taken while the previous response still waits; a
//  finished result then holds until the response register frees up.
//  Reset is synchronous; no clearing pass is needed after it.
//
`default_nettype none

module signed_int32_alu_mul_div_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [3:0]                       i_req_type,
    input  logic signed [ialu_pkg::DW-1:0]   i_operand_a,
    input  logic signed [ialu_pkg::DW-1:0]   i_operand_b,
    output logic                             o_rsp_valid,
    input  logic                             i_rsp_ready,
    output logic signed [ialu_pkg::DW-1:0]   o_result,
    output logic [1:0]                       o_error_code
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_MULDIV = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FIX    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam int W = ialu_pkg::DW;

    logic [2:0]   r_state, n_state;
    logic [3:0]   r_op;
    logic [W-1:0] r_a, r_b;
    logic         r_neg, n_neg;
    logic         r_div;
    logic [W-1:0] r_res, n_res;
    logic [1:0]   r_err, n_err;
    logic         r_rsp_valid, n_rsp_valid;
    logic [W-1:0] r_result;
    logic [1:0]   r_error;

    logic [W-1:0] w_sum, w_dif, w_mag_a, w_mag_b, w_fix_src;
    logic         w_out_free;
    logic         w_lo_is_min;

    ialu_pkg::t_md_cmd       w_md_cmd;
    ialu_pkg::t_sh_cmd       w_sh_cmd;
    logic                    w_md_done, w_sh_done;
    logic [W-1:0]            w_md_hi, w_md_lo, w_sh_data;

    ialu_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_md_cmd),
        .i_op_x  (w_mag_b),
        .i_op_y  (w_mag_a),
        .o_done  (w_md_done),
        .o_hi    (w_md_hi),
        .o_lo    (w_md_lo)
    );

    ialu_shift u_shift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_sh_cmd),
        .i_data   (r_a),
        .i_amount (r_b[ialu_pkg::CW-1:0]),
        .o_done   (w_sh_done),
        .o_data   (w_sh_data)
    );

    assign w_sum   = r_a + r_b;
    assign w_dif   = r_a - r_b;
    assign w_mag_a = r_a[W-1] ? -r_a : r_a;
    assign w_mag_b = r_b[W-1] ? -r_b : r_b;

    // Low product half equal to 2^(W-1) only fits when the result is negative.
    assign w_lo_is_min = w_md_lo[W-1] && (w_md_lo[W-2:0] == '0);
    assign w_fix_src   = w_md_lo;

    assign w_out_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_err    = r_err;
        n_neg    = r_neg;
        w_md_cmd = '0;
        w_sh_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_res   = '0;
                n_err   = ialu_pkg::ERR_OK;
                n_neg   = r_a[W-1] ^ r_b[W-1];
                n_state = S_DONE;
                case (r_op) inside
                    ialu_pkg::OP_ADD: begin
                        n_res = w_sum;
                        if ((r_a[W-1] == r_b[W-1]) && (w_sum[W-1] != r_a[W-1])) begin
                            n_err = ialu_pkg::ERR_OVF;
                        end
                    end
                    ialu_pkg::OP_SUB: begin
                        n_res = w_dif;
                        if ((r_a[W-1] != r_b[W-1]) && (w_dif[W-1] != r_a[W-1])) begin
                            n_err = ialu_pkg::ERR_OVF;
                        end
                    end
                    ialu_pkg::OP_MUL: begin
                        w_md_cmd.start  = 1'b1;
                        w_md_cmd.is_div = 1'b0;
                        n_state         = S_MULDIV;
                    end
                    ialu_pkg::OP_DIV: begin
                        if (r_b == '0) begin
                            n_err = ialu_pkg::ERR_DIV0;
                        end else begin
                            w_md_cmd.start  = 1'b1;
                            w_md_cmd.is_div = 1'b1;
                            n_state         = S_MULDIV;
                        end
                    end
                    ialu_pkg::OP_AND: n_res = r_a & r_b;
                    ialu_pkg::OP_OR:  n_res = r_a | r_b;
                    ialu_pkg::OP_XOR: n_res = r_a ^ r_b;
                    ialu_pkg::OP_NOT: n_res = ~r_a;
                    ialu_pkg::OP_SHL, ialu_pkg::OP_SHR: begin
                        if (r_b[W-1] || (r_b > ialu_pkg::SHIFT_MAX)) begin
                            n_err = ialu_pkg::ERR_SHIFT;
                        end else begin
                            w_sh_cmd.start = 1'b1;
                            w_sh_cmd.left  = (r_op == ialu_pkg::OP_SHL);
                            n_state        = S_SHIFT;
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_MULDIV: begin
                if (w_md_done) begin
                    n_state = S_FIX;
                end
            end
            S_SHIFT: begin
                if (w_sh_done) begin
                    n_res   = w_sh_data;
                    n_state = S_DONE;
                end
            end
            S_FIX: begin
                n_res = r_neg ? -w_fix_src : w_fix_src;
                if (r_div) begin
                    if (w_md_lo[W-1] && !r_neg) begin
                        n_err = ialu_pkg::ERR_OVF;
                    end
                end else if ((w_md_hi != '0) ||
                             (w_md_lo[W-1] && !(r_neg && w_lo_is_min))) begin
                    n_err = ialu_pkg::ERR_OVF;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if ((r_state == S_DONE) && w_out_free) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_req_valid) begin
            r_op <= i_req_type;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
        if (w_md_cmd.start) begin
            r_div <= w_md_cmd.is_div;
        end
        r_res <= n_res;
        r_err <= n_err;
        r_neg <= n_neg;
        if ((r_state == S_DONE) && w_out_free) begin
            r_result <= r_res;
            r_error  <= r_err;
        end
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_rsp_valid  = r_rsp_valid;
    assign o_result     = r_result;
    assign o_error_code = r_error;

endmodule

`default_nettype wire

// File: verif/tb_signed_int32_alu_mul_div_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int32_alu_mul_div_top
// Drives request beats through the 32-bit signed ALU with random idle gaps on
// both channels and checks every response beat, in order, against a built-in
// predictor of the result and error code. A directed set of corner cases runs
// first, then random traffic. The traffic includes one long response stall
// and four pauses on the request side until all results are back.
// ----------------------------------------------------------------------------

module tb_signed_int32_alu_mul_div_top;

    import ialu_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     RANDOM_REQS  = 825;
    localparam int     DRAIN_CYCLES = 50;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        int                 gap_after;
        bit                 drain;
    } alu_req_t;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] res;
        logic [1:0]         err;
    } alu_rsp_t;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_req_valid  = 1'b0;
    logic               o_req_ready;
    logic [3:0]         i_req_type   = '0;
    logic signed [31:0] i_operand_a  = '0;
    logic signed [31:0] i_operand_b  = '0;
    logic               o_rsp_valid;
    logic               i_rsp_ready  = 1'b0;
    logic signed [31:0] o_result;
    logic [1:0]         o_error_code;

    alu_req_t req_backlog[$];
    alu_rsp_t results_due[$];

    int n_accepted  = 0;
    int n_returned  = 0;
    int n_mismatch  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    int       idle_left  = 0;
    int       stall_left = 0;
    bit       req_fire;
    alu_req_t next_req;
    alu_rsp_t want;

    signed_int32_alu_mul_div_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_result     (o_result),
        .o_error_code (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Expected result and error code of one request.
    function automatic alu_rsp_t alu_predict(input logic [3:0] op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        longint   sa;
        longint   sb;
        longint   wide;
        alu_rsp_t o;
        sa    = a;
        sb    = b;
        wide  = 0;
        o.op  = op;
        o.a   = a;
        o.b   = b;
        o.res = '0;
        o.err = ERR_OK;
        case (op)
            OP_ADD, OP_SUB, OP_MUL: begin
                if (op == OP_ADD)      wide = sa + sb;
                else if (op == OP_SUB) wide = sa - sb;
                else                   wide = sa * sb;
                o.res = wide[31:0];
                if (wide > S32_MAX || wide < S32_MIN) o.err = ERR_OVF;
            end
            OP_DIV: begin
                if (sb == 0) begin
                    o.err = ERR_DIV0;
                end else begin
                    // Longint division truncates toward zero, as the block does.
                    wide  = sa / sb;
                    o.res = wide[31:0];
                    if (wide > S32_MAX) o.err = ERR_OVF;
                end
            end
            OP_AND: o.res = a & b;
            OP_OR:  o.res = a | b;
            OP_XOR: o.res = a ^ b;
            OP_NOT: o.res = ~a;
            OP_SHL, OP_SHR: begin
                if (sb < 0 || sb > longint'(SHIFT_MAX)) begin
                    o.err = ERR_SHIFT;
                end else if (op == OP_SHL) begin
                    o.res = a <<< b[4:0];
                end else begin
                    o.res = a >>> b[4:0];
                end
            end
            default: begin
                o.res = '0;
                o.err = ERR_OK;
            end
        endcase
        return o;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       return MIN32;
            1:       return MAX32;
            2:       return '0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5, 6:    return $urandom_range(0, 200) - 100;
            7:       return $urandom_range(0, 131071) - 65536;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [31:0] pick_shift();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'sd31;
            1:       return 32'sd32;
            2:       return -32'sd1;
            3:       return $urandom();
            default: return $urandom_range(0, 30);
        endcase
    endfunction

    task automatic queue_req(input logic [3:0] op, input logic signed [31:0] a,
                             input logic signed [31:0] b, input int gap, input bit drain);
        alu_req_t r;
        r.op        = op;
        r.a         = a;
        r.b         = b;
        r.gap_after = gap;
        r.drain     = drain;
        req_backlog.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input alu_rsp_t exp_rsp);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("[%0t] %s: op %0d a %0d b %0d exp %0d/%0d got %0d/%0d", $time, what,
                     exp_rsp.op, exp_rsp.a, exp_rsp.b, exp_rsp.res, exp_rsp.err,
                     o_result, o_error_code);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            req_fire = i_req_valid && o_req_ready;
            if (req_fire) begin
                results_due.push_back(alu_predict(i_req_type, i_operand_a, i_operand_b));
                n_accepted <= n_accepted + 1;
            end
            if (!i_req_valid || req_fire) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_req_valid <= 1'b0;
                end else if (req_backlog.size() > 0 &&
                             (!req_backlog[0].drain ||
                              n_accepted + (req_fire ? 1 : 0) == n_returned)) begin
                    next_req = req_backlog.pop_front();
                    i_req_type  <= next_req.op;
                    i_operand_a <= next_req.a;
                    i_operand_b <= next_req.b;
                    i_req_valid <= 1'b1;
                    idle_left = next_req.gap_after;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                n_returned <= n_returned + 1;
                if (results_due.size() == 0) begin
                    want = '{default: '0};
                    note_mismatch("unexpected beat", want);
                end else begin
                    want = results_due.pop_front();
                    if (o_result !== want.res || o_error_code !== want.err)
                        note_mismatch("mismatch", want);
                end
            end
            if (hold_left > 0) begin
                i_rsp_ready <= 1'b0;
            end else if (((n_returned / 100) % 3) == 2) begin
                i_rsp_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // One long hold-off on the response side so the block backs up into the
    // request channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_returned == 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Overflow on add and subtract, both directions.
        queue_req(OP_ADD, MAX32, 32'sd1, 0, 1'b0);
        queue_req(OP_ADD, MIN32, -32'sd1, 0, 1'b0);
        queue_req(OP_ADD, -32'sd5, 32'sd12, 0, 1'b0);
        queue_req(OP_SUB, MIN32, 32'sd1, 0, 1'b0);
        queue_req(OP_SUB, MAX32, -32'sd1, 0, 1'b0);
        // Multiply: the product MIN is legal only when negative.
        queue_req(OP_MUL, MIN32, -32'sd1, 0, 1'b0);
        queue_req(OP_MUL, MIN32, 32'sd1, 0, 1'b0);
        queue_req(OP_MUL, 32'sd65536, 32'sd32768, 0, 1'b0);
        queue_req(OP_MUL, -32'sd65536, 32'sd32768, 0, 1'b0);
        queue_req(OP_MUL, -32'sd7, 32'sd3, 0, 1'b0);
        // Divide: truncation, MIN by minus one, divide by zero.
        queue_req(OP_DIV, 32'sd7, -32'sd2, 0, 1'b0);
        queue_req(OP_DIV, MIN32, -32'sd1, 0, 1'b0);
        queue_req(OP_DIV, 32'sd5, 32'sd0, 0, 1'b0);
        queue_req(OP_DIV, MIN32, 32'sd1, 0, 1'b0);
        queue_req(OP_AND, -32'sd1, 32'sh5a5a_a5a5, 0, 1'b0);
        queue_req(OP_OR, MIN32, 32'sh0f0f_0f0f, 0, 1'b0);
        queue_req(OP_XOR, -32'sd1, MAX32, 0, 1'b0);
        queue_req(OP_NOT, MIN32, 32'sd0, 0, 1'b0);
        // Shifts: largest legal amount, out-of-range and negative amounts.
        queue_req(OP_SHL, -32'sd1, 32'sd30, 0, 1'b0);
        queue_req(OP_SHL, 32'sd1, 32'sd31, 0, 1'b0);
        queue_req(OP_SHL, 32'sd1, -32'sd1, 0, 1'b0);
        queue_req(OP_SHR, MIN32, 32'sd30, 0, 1'b0);
        queue_req(OP_SHR, MAX32, 32'sd0, 0, 1'b0);
        // Unused operation codes.
        queue_req(4'd10, MAX32, MIN32, 0, 1'b0);
        queue_req(4'd15, -32'sd1, -32'sd1, 0, 1'b0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            logic [3:0]         op;
            logic signed [31:0] a;
            logic signed [31:0] b;
            int                 gap;
            if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(10, 15));
            else                            op = 4'($urandom_range(0, 9));
            a = pick_operand();
            if (op == OP_SHL || op == OP_SHR)   b = pick_shift();
            else if (op == OP_DIV && $urandom_range(0, 9) == 0) b = '0;
            else                                b = pick_operand();
            // Every third block of a hundred requests runs back to back.
            gap = (((i / 100) % 3) == 1) ? 0 : pick_gap();
            queue_req(op, a, b, gap, (i % 250) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || i_req_valid) @(posedge i_clk);
        while (n_returned != n_accepted) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0) begin
            n_mismatch++;
            $display("%0d expected beats never arrived", results_due.size());
        end

        if (n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
